@@ rtl/mca_pkg.sv @@
// shared constants, types and helper functions of the mean and covariance accumulator
package mca_pkg;

    // default sizes
    localparam int MAX_DIM_DEF      = 8;
    localparam int MAX_FRAMES_DEF   = 4096;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // widest sample the queue carries
    localparam int SAMPLE_MAX_W = 24;

    // dimension register
    localparam int              DIMS_W     = 4;
    localparam logic [DIMS_W-1:0] DIMS_RESET = 4'd8;

    // sample queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QP_W        = 2;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_PARTIAL   = 2'd1;
    localparam logic [1:0] STATUS_NO_FRAMES = 2'd2;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd3;

    // arithmetic unit operations
    localparam logic OP_MUL = 1'b0;
    localparam logic OP_DIV = 1'b1;

    // one queued request
    typedef struct packed {
        logic signed [SAMPLE_MAX_W-1:0] value;
        logic                           last;
    } queue_entry_t;

    // command to the iterative arithmetic unit
    typedef struct packed {
        logic        start;
        logic        op;
        logic [63:0] opa;
        logic [63:0] opb;
    } arith_cmd_t;

    // response of the iterative arithmetic unit
    typedef struct packed {
        logic        done;
        logic [63:0] value;
    } arith_rsp_t;

    // sign extend the low w bits of x to 64 bits
    function automatic logic [63:0] sext64(input logic [63:0] x, input int w);
        logic [63:0] r;
        for (int k = 0; k < 64; k++)
        begin
            r[k] = (k < w) ? x[k] : x[w-1];
        end
        return r;
    endfunction

endpackage

@@ rtl/mean_covariance_accumulator.sv @@
// top level of the mean and covariance accumulator
//
// Samples enter one request at a time on start/busy with sample and last_sample;
// a request is taken when start is high and busy is low. busy rises only when
// the four-entry queue between front and back end is full.
// The dimension count is written on cfg_valid/cfg_ready/cfg_data (ready is
// always high); the user must write it only while no run is in progress,
// which the block itself does not enforce; it resets to 8. A sample that
// completes a frame of d dimensions starts the accumulation through one
// multiplier and the cross-sum ram port; the queue keeps taking samples
// meanwhile until it is full. After the sample marked last, results appear
// on result_valid for one cycle each, row-major over d*d entries, or as a
// single result for a run with no complete frame. Each row costs one mean
// division and each entry two shift-add multiplies plus one 64-step division
// in the shared iterative unit. The receiver cannot stall; results are not held.
// Reset clears the queue, the sums and counters and sets the dimension
// count to 8; the sum stores use valid bits, so no clearing pass is needed.
module mean_covariance_accumulator #(
    parameter int MAX_DIM      = mca_pkg::MAX_DIM_DEF,
    parameter int MAX_FRAMES   = mca_pkg::MAX_FRAMES_DEF,
    parameter int SAMPLE_WIDTH = mca_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           last_sample,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mca_pkg::DIMS_W-1:0]     cfg_data,
    output logic                           result_valid,
    output logic [2:0]                     row,
    output logic [2:0]                     col,
    output logic signed [23:0]             row_mean,
    output logic signed [31:0]             covariance,
    output logic [12:0]                    frame_count,
    output logic [1:0]                     status,
    output logic                           last
);

    logic [mca_pkg::DIMS_W-1:0] dims_reg;
    logic                       q_pop;
    logic                       q_empty;
    mca_pkg::queue_entry_t      q_entry;

    // dimension count register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg <= mca_pkg::DIMS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            dims_reg <= cfg_data;
        end
    end

    mca_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .sample      (sample),
        .last_sample (last_sample),
        .pop         (q_pop),
        .empty       (q_empty),
        .entry       (q_entry)
    );

    mca_back #(
        .MAX_DIM      (MAX_DIM),
        .MAX_FRAMES   (MAX_FRAMES),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .dims         (dims_reg),
        .q_empty      (q_empty),
        .q_entry      (q_entry),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .row          (row),
        .col          (col),
        .row_mean     (row_mean),
        .covariance   (covariance),
        .frame_count  (frame_count),
        .status       (status),
        .last         (last)
    );

endmodule

@@ rtl/mca_ram.sv @@
// generic single write, single read ram with registered read data
module mca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/mca_front.sv @@
// front end: takes sample requests, sign extends them and queues them for the back end
module mca_front #(
    parameter int SAMPLE_WIDTH = mca_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           last_sample,
    input  logic                           pop,
    output logic                           empty,
    output mca_pkg::queue_entry_t          entry
);

    mca_pkg::queue_entry_t q_mem [mca_pkg::QUEUE_DEPTH];

    logic [mca_pkg::QP_W-1:0] wr_reg, wr_next;
    logic [mca_pkg::QP_W-1:0] rd_reg, rd_next;
    logic [mca_pkg::QP_W:0]   cnt_reg, cnt_next;
    logic                     push;
    logic [63:0]              sample_x;

    assign busy  = (cnt_reg == (mca_pkg::QP_W + 1)'(mca_pkg::QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign push  = start && !busy;
    assign entry = q_mem[rd_reg];

    // widen the sample to the queue format
    assign sample_x = mca_pkg::sext64(64'(sample), SAMPLE_WIDTH);

    // pointer and fill count update
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_reg].value <= sample_x[mca_pkg::SAMPLE_MAX_W-1:0];
            q_mem[wr_reg].last  <= last_sample;
        end
    end

endmodule

@@ rtl/mca_arith.sv @@
// iterative unit: shift-add multiply and restoring signed divide on 64-bit words
module mca_arith #(
    parameter int MUL_W = 29,
    parameter int DEN_W = 26
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mca_pkg::arith_cmd_t cmd,
    output mca_pkg::arith_rsp_t rsp
);

    localparam int CNT_W = 6;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic               op_reg, op_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [63:0]        acc_reg, acc_next;
    logic [63:0]        mcand_reg, mcand_next;
    logic [MUL_W-1:0]   mplier_reg, mplier_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [DEN_W-1:0]   rem_reg, rem_next;
    logic [63:0]        quo_reg, quo_next;
    logic               neg_reg, neg_next;
    logic [DEN_W:0]     trial;
    logic [DEN_W:0]     trial_sub;
    logic               mul_last;
    logic               div_last;

    assign mul_last  = (cnt_reg == CNT_W'(MUL_W - 1));
    assign div_last  = (cnt_reg == CNT_W'(63));
    assign trial     = {rem_reg, quo_reg[63]};
    assign trial_sub = trial - {1'b0, den_reg};

    // one multiplier bit or one quotient bit per cycle
    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        op_next     = op_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        neg_next    = neg_reg;
        if (cmd.start)
        begin
            busy_next   = 1'b1;
            op_next     = cmd.op;
            cnt_next    = '0;
            acc_next    = '0;
            mcand_next  = cmd.opa;
            mplier_next = cmd.opb[MUL_W-1:0];
            den_next    = cmd.opb[DEN_W-1:0];
            rem_next    = '0;
            neg_next    = cmd.opa[63];
            quo_next    = cmd.opa[63] ? (64'd0 - cmd.opa) : cmd.opa;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (op_reg == mca_pkg::OP_MUL)
            begin
                // top multiplier bit carries negative weight
                if (mplier_reg[0])
                begin
                    acc_next = mul_last ? (acc_reg - mcand_reg) : (acc_reg + mcand_reg);
                end
                mcand_next  = {mcand_reg[62:0], 1'b0};
                mplier_next = mplier_reg >> 1;
                if (mul_last)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
            else
            begin
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next = trial_sub[DEN_W-1:0];
                    quo_next = {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[DEN_W-1:0];
                    quo_next = {quo_reg[62:0], 1'b0};
                end
                if (div_last)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        neg_reg    <= neg_next;
    end

    // quotient sign restored on the way out
    assign rsp.done  = done_reg;
    assign rsp.value = (op_reg == mca_pkg::OP_DIV)
                     ? (neg_reg ? (64'd0 - quo_reg) : quo_reg)
                     : acc_reg;

endmodule

@@ rtl/mca_back.sv @@
// back end: frame buffer, sum accumulation and the mean and covariance readout
module mca_back #(
    parameter int MAX_DIM      = mca_pkg::MAX_DIM_DEF,
    parameter int MAX_FRAMES   = mca_pkg::MAX_FRAMES_DEF,
    parameter int SAMPLE_WIDTH = mca_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [mca_pkg::DIMS_W-1:0]  dims,
    input  logic                        q_empty,
    input  mca_pkg::queue_entry_t       q_entry,
    output logic                        q_pop,
    output logic                        result_valid,
    output logic [2:0]                  row,
    output logic [2:0]                  col,
    output logic signed [23:0]          row_mean,
    output logic signed [31:0]          covariance,
    output logic [12:0]                 frame_count,
    output logic [1:0]                  status,
    output logic                        last
);

    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CA_D   = MAX_DIM * MAX_DIM;
    localparam int CA_W   = (CA_D > 1) ? $clog2(CA_D) : 1;
    localparam int FC_W   = $clog2(MAX_FRAMES + 1);
    localparam int LOGF   = $clog2(MAX_FRAMES);
    localparam int SUM_W  = SAMPLE_WIDTH + LOGF;
    localparam int CROSS_W = (2 * SAMPLE_WIDTH + LOGF > 64) ? 64 : 2 * SAMPLE_WIDTH + LOGF;
    localparam int MUL_W  = (SUM_W > FC_W + 1) ? SUM_W : FC_W + 1;
    localparam int DEN_W  = 2 * FC_W;

    // sequencer states
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_ROW       = 4'd1;
    localparam logic [3:0] S_ROW1      = 4'd2;
    localparam logic [3:0] S_COL       = 4'd3;
    localparam logic [3:0] S_DRAIN     = 4'd4;
    localparam logic [3:0] S_FIN       = 4'd5;
    localparam logic [3:0] S_MEAN_RD   = 4'd6;
    localparam logic [3:0] S_MEAN_GO   = 4'd7;
    localparam logic [3:0] S_MEAN_WAIT = 4'd8;
    localparam logic [3:0] S_COV_RD    = 4'd9;
    localparam logic [3:0] S_COV_M1    = 4'd10;
    localparam logic [3:0] S_COV_W1    = 4'd11;
    localparam logic [3:0] S_COV_W2    = 4'd12;
    localparam logic [3:0] S_COV_WD    = 4'd13;

    logic [3:0]        st_reg, st_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [IDX_W-1:0]  ei_reg, ei_next;
    logic [FC_W-1:0]   frames_reg, frames_next;
    logic              ovf_reg, ovf_next;
    logic              lastp_reg, lastp_next;
    logic              p1v_reg, p1v_next;
    logic              p2v_reg;
    logic [MAX_DIM-1:0] dvalid_reg, dvalid_next;
    logic [CA_D-1:0]   cvalid_reg, cvalid_next;
    logic              dvalid_q_reg;
    logic              cvalid_q_reg;

    // payload registers
    logic signed [SAMPLE_WIDTH-1:0]   a_reg;
    logic signed [2*SAMPLE_WIDTH-1:0] prod_reg;
    logic [CROSS_W-1:0]               ccur_reg;
    logic [CA_W-1:0]                  p1_addr_reg;
    logic [CA_W-1:0]                  p2_addr_reg;
    logic [DEN_W-1:0]                 nn_reg;
    logic [1:0]                       status_reg;
    logic [SUM_W-1:0]                 si_reg;
    logic [SUM_W-1:0]                 sj_reg;
    logic [63:0]                      t1_reg;
    logic [23:0]                      mean_reg;

    // output registers
    logic              rv_reg;
    logic [2:0]        row_reg;
    logic [2:0]        col_reg;
    logic [23:0]       mean_out_reg;
    logic [31:0]       cov_out_reg;
    logic [12:0]       fc_out_reg;
    logic [1:0]        status_out_reg;
    logic              last_out_reg;

    logic [IDX_W-1:0]  dm1;
    logic              clear_run;
    logic              emit;
    logic              emit_empty;

    // memory ports
    logic                    fb_we;
    logic [IDX_W-1:0]        fb_raddr;
    logic [SAMPLE_WIDTH-1:0] fb_rdata;
    logic                    dim_we;
    logic [IDX_W-1:0]        dim_raddr;
    logic [SUM_W-1:0]        dim_wdata;
    logic [SUM_W-1:0]        dim_rdata;
    logic [CA_W-1:0]         cross_addr;
    logic [CROSS_W-1:0]      cross_wdata;
    logic [CROSS_W-1:0]      cross_rdata;

    logic [SUM_W-1:0]        dsum_cur;
    logic [CROSS_W-1:0]      cross_cur;
    logic [63:0]             fb_x;
    logic [63:0]             prod_x;
    logic [63:0]             frames64;
    logic [63:0]             i64;
    logic [63:0]             j64;

    mca_pkg::arith_cmd_t     acmd;
    mca_pkg::arith_rsp_t     arsp;

    // active dimension count less one, clamped to the supported range
    always_comb
    begin
        if (dims == '0)
        begin
            dm1 = '0;
        end
        else if (5'(dims) > 5'(MAX_DIM))
        begin
            dm1 = IDX_W'(MAX_DIM - 1);
        end
        else
        begin
            dm1 = IDX_W'(dims - 1'b1);
        end
    end

    // stores whose reset is zero read through their valid bits
    assign dsum_cur  = dvalid_q_reg ? dim_rdata : '0;
    assign cross_cur = cvalid_q_reg ? cross_rdata : '0;

    assign fb_x     = mca_pkg::sext64(64'(fb_rdata), SAMPLE_WIDTH);
    assign prod_x   = mca_pkg::sext64(64'(prod_reg), 2 * SAMPLE_WIDTH);
    assign frames64 = 64'(frames_reg);
    assign i64      = 64'(i_reg);
    assign j64      = 64'(j_reg);

    // memory addressing
    assign fb_raddr    = (st_reg == S_COL) ? j_reg : i_reg;
    assign dim_raddr   = (st_reg == S_COV_RD) ? j_reg : i_reg;
    assign cross_addr  = CA_W'(int'(i_reg) * MAX_DIM + int'(j_reg));
    assign fb_we       = (st_reg == S_IDLE) && !q_empty;
    assign dim_we      = (st_reg == S_ROW1);
    assign dim_wdata   = dsum_cur + fb_x[SUM_W-1:0];
    assign cross_wdata = ccur_reg + prod_x[CROSS_W-1:0];
    assign q_pop       = fb_we;

    mca_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(MAX_DIM)) u_frame_ram (
        .clk   (clk),
        .we    (fb_we),
        .waddr (ei_reg),
        .wdata (q_entry.value[SAMPLE_WIDTH-1:0]),
        .raddr (fb_raddr),
        .rdata (fb_rdata)
    );

    mca_ram #(.WIDTH(SUM_W), .DEPTH(MAX_DIM)) u_dim_ram (
        .clk   (clk),
        .we    (dim_we),
        .waddr (i_reg),
        .wdata (dim_wdata),
        .raddr (dim_raddr),
        .rdata (dim_rdata)
    );

    mca_ram #(.WIDTH(CROSS_W), .DEPTH(CA_D)) u_cross_ram (
        .clk   (clk),
        .we    (p2v_reg),
        .waddr (p2_addr_reg),
        .wdata (cross_wdata),
        .raddr (cross_addr),
        .rdata (cross_rdata)
    );

    mca_arith #(.MUL_W(MUL_W), .DEN_W(DEN_W)) u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (acmd),
        .rsp   (arsp)
    );

    // sequencer
    always_comb
    begin
        st_next     = st_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        ei_next     = ei_reg;
        frames_next = frames_reg;
        ovf_next    = ovf_reg;
        lastp_next  = lastp_reg;
        p1v_next    = 1'b0;
        dvalid_next = dvalid_reg;
        cvalid_next = cvalid_reg;
        clear_run   = 1'b0;
        emit        = 1'b0;
        emit_empty  = 1'b0;
        acmd.start  = 1'b0;
        acmd.op     = mca_pkg::OP_MUL;
        acmd.opa    = '0;
        acmd.opb    = '0;

        if (p2v_reg)
        begin
            cvalid_next[p2_addr_reg] = 1'b1;
        end

        case (st_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    lastp_next = q_entry.last;
                    if (ei_reg >= dm1)
                    begin
                        ei_next = '0;
                        if (frames_reg >= FC_W'(MAX_FRAMES))
                        begin
                            ovf_next = 1'b1;
                            st_next  = q_entry.last ? S_FIN : S_IDLE;
                        end
                        else
                        begin
                            frames_next = frames_reg + 1'b1;
                            i_next      = '0;
                            st_next     = S_ROW;
                        end
                    end
                    else
                    begin
                        ei_next = ei_reg + 1'b1;
                        st_next = q_entry.last ? S_FIN : S_IDLE;
                    end
                end
            end
            S_ROW:
            begin
                st_next = S_ROW1;
            end
            S_ROW1:
            begin
                dvalid_next[i_reg] = 1'b1;
                j_next  = '0;
                st_next = S_COL;
            end
            S_COL:
            begin
                p1v_next = 1'b1;
                if (j_reg == dm1)
                begin
                    if (i_reg == dm1)
                    begin
                        st_next = S_DRAIN;
                    end
                    else
                    begin
                        i_next  = i_reg + 1'b1;
                        st_next = S_ROW;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (!p1v_reg && !p2v_reg)
                begin
                    st_next = lastp_reg ? S_FIN : S_IDLE;
                end
            end
            S_FIN:
            begin
                if (frames_reg == '0)
                begin
                    emit_empty = 1'b1;
                    clear_run  = 1'b1;
                    st_next    = S_IDLE;
                end
                else
                begin
                    i_next  = '0;
                    st_next = S_MEAN_RD;
                end
            end
            S_MEAN_RD:
            begin
                st_next = S_MEAN_GO;
            end
            S_MEAN_GO:
            begin
                acmd.start = 1'b1;
                acmd.op    = mca_pkg::OP_DIV;
                acmd.opa   = {mca_pkg::sext64(64'(dsum_cur), SUM_W)} << 8;
                acmd.opb   = frames64;
                st_next    = S_MEAN_WAIT;
            end
            S_MEAN_WAIT:
            begin
                if (arsp.done)
                begin
                    j_next  = '0;
                    st_next = S_COV_RD;
                end
            end
            S_COV_RD:
            begin
                st_next = S_COV_M1;
            end
            S_COV_M1:
            begin
                acmd.start = 1'b1;
                acmd.op    = mca_pkg::OP_MUL;
                acmd.opa   = mca_pkg::sext64(64'(cross_cur), CROSS_W);
                acmd.opb   = frames64;
                st_next    = S_COV_W1;
            end
            S_COV_W1:
            begin
                if (arsp.done)
                begin
                    acmd.start = 1'b1;
                    acmd.op    = mca_pkg::OP_MUL;
                    acmd.opa   = mca_pkg::sext64(64'(si_reg), SUM_W);
                    acmd.opb   = mca_pkg::sext64(64'(sj_reg), SUM_W);
                    st_next    = S_COV_W2;
                end
            end
            S_COV_W2:
            begin
                if (arsp.done)
                begin
                    acmd.start = 1'b1;
                    acmd.op    = mca_pkg::OP_DIV;
                    acmd.opa   = t1_reg - arsp.value;
                    acmd.opb   = 64'(nn_reg);
                    st_next    = S_COV_WD;
                end
            end
            S_COV_WD:
            begin
                if (arsp.done)
                begin
                    emit = 1'b1;
                    if (j_reg == dm1)
                    begin
                        if (i_reg == dm1)
                        begin
                            clear_run = 1'b1;
                            st_next   = S_IDLE;
                        end
                        else
                        begin
                            i_next  = i_reg + 1'b1;
                            st_next = S_MEAN_RD;
                        end
                    end
                    else
                    begin
                        j_next  = j_reg + 1'b1;
                        st_next = S_COV_RD;
                    end
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase

        // end of run clears the sums and counters
        if (clear_run)
        begin
            dvalid_next = '0;
            cvalid_next = '0;
            ei_next     = '0;
            frames_next = '0;
            ovf_next    = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= S_IDLE;
            i_reg        <= '0;
            j_reg        <= '0;
            ei_reg       <= '0;
            frames_reg   <= '0;
            ovf_reg      <= 1'b0;
            lastp_reg    <= 1'b0;
            p1v_reg      <= 1'b0;
            p2v_reg      <= 1'b0;
            dvalid_reg   <= '0;
            cvalid_reg   <= '0;
            dvalid_q_reg <= 1'b0;
            cvalid_q_reg <= 1'b0;
            rv_reg       <= 1'b0;
        end
        else
        begin
            st_reg       <= st_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            ei_reg       <= ei_next;
            frames_reg   <= frames_next;
            ovf_reg      <= ovf_next;
            lastp_reg    <= lastp_next;
            p1v_reg      <= p1v_next;
            p2v_reg      <= p1v_reg;
            dvalid_reg   <= dvalid_next;
            cvalid_reg   <= cvalid_next;
            dvalid_q_reg <= dvalid_reg[dim_raddr];
            cvalid_q_reg <= cvalid_reg[cross_addr];
            rv_reg       <= emit || emit_empty;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        // accumulation pipeline: multiply, then read-modify-write of the cross sum
        if (st_reg == S_ROW1)
        begin
            a_reg <= $signed(fb_rdata);
        end
        prod_reg    <= a_reg * $signed(fb_rdata);
        ccur_reg    <= cross_cur;
        p1_addr_reg <= cross_addr;
        p2_addr_reg <= p1_addr_reg;

        // readout operands
        if (st_reg == S_FIN)
        begin
            nn_reg     <= frames_reg * frames_reg;
            status_reg <= ovf_reg ? mca_pkg::STATUS_OVERFLOW
                        : ((ei_reg != '0) ? mca_pkg::STATUS_PARTIAL : mca_pkg::STATUS_OK);
        end
        if (st_reg == S_MEAN_GO)
        begin
            si_reg <= dsum_cur;
        end
        if (st_reg == S_MEAN_WAIT && arsp.done)
        begin
            mean_reg <= arsp.value[23:0];
        end
        if (st_reg == S_COV_M1)
        begin
            sj_reg <= dsum_cur;
        end
        if (st_reg == S_COV_W1 && arsp.done)
        begin
            t1_reg <= arsp.value;
        end

        // result registers
        if (emit_empty)
        begin
            row_reg        <= '0;
            col_reg        <= '0;
            mean_out_reg   <= '0;
            cov_out_reg    <= '0;
            fc_out_reg     <= '0;
            status_out_reg <= mca_pkg::STATUS_NO_FRAMES;
            last_out_reg   <= 1'b1;
        end
        else if (emit)
        begin
            row_reg        <= i64[2:0];
            col_reg        <= j64[2:0];
            mean_out_reg   <= mean_reg;
            cov_out_reg    <= arsp.value[31:0];
            fc_out_reg     <= frames64[12:0];
            status_out_reg <= status_reg;
            last_out_reg   <= (i_reg == dm1) && (j_reg == dm1);
        end
    end

    assign result_valid = rv_reg;
    assign row          = row_reg;
    assign col          = col_reg;
    assign row_mean     = mean_out_reg;
    assign covariance   = cov_out_reg;
    assign frame_count  = fc_out_reg;
    assign status       = status_out_reg;
    assign last         = last_out_reg;

`ifndef NO_ASSERTIONS
    // the final result of a run is never directly followed by another
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |=> !result_valid)
        else $error("result right after the final result of a run");

    // cross sum writes belong to the accumulation phase only
    a_cross_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        p2v_reg |-> (st_reg == S_ROW || st_reg == S_ROW1 || st_reg == S_COL
                     || st_reg == S_DRAIN))
        else $error("cross sum written outside accumulation");

    // an empty run reports a single zero result
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == mca_pkg::STATUS_NO_FRAMES)
            |-> (last && covariance == '0 && frame_count == '0))
        else $error("empty run result malformed");

    // the queue is only popped when it holds a request
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("pop from an empty queue");

    // a new arithmetic command is only issued during readout
    a_arith_phase: assert property (@(posedge clk) disable iff (!rst_n)
        acmd.start |-> (st_reg == S_MEAN_GO || st_reg == S_COV_M1
                        || st_reg == S_COV_W1 || st_reg == S_COV_W2))
        else $error("arithmetic command outside readout");
`endif

endmodule

@@ tb/sv/mean_covariance_accumulator_tb.sv @@
// testbench of the mean and covariance accumulator: random data sets checked against a predictor
module mean_covariance_accumulator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIMS_MAX   = 8;
    localparam int FRAMES_CAP = 4096;
    localparam int SETTLE     = 400;

    typedef enum logic { REQ_SAMPLE, REQ_CFG } req_kind_t;

    typedef struct {
        req_kind_t   kind;
        logic [15:0] value;
        logic        last_flag;
        logic [3:0]  dims;
    } request_t;

    typedef struct {
        logic [2:0]  row;
        logic [2:0]  col;
        logic [23:0] row_mean;
        logic [31:0] covariance;
        logic [12:0] frame_count;
        logic [1:0]  status;
        logic        last;
    } entry_t;

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic signed [15:0]          sample;
    logic                        last_sample;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [mca_pkg::DIMS_W-1:0]  cfg_data;
    logic                        result_valid;
    logic [2:0]                  row;
    logic [2:0]                  col;
    logic signed [23:0]          row_mean;
    logic signed [31:0]          covariance;
    logic [12:0]                 frame_count;
    logic [1:0]                  status;
    logic                        last;

    request_t pending_reqs[$];
    entry_t   expected_entries[$];
    int       fail_count;
    int       accepted_count;
    int       settle_count;
    logic     stimulus_done;

    // predictor state
    logic [3:0]  dims_reg;
    logic [63:0] frame_buf[DIMS_MAX];
    logic [63:0] dim_sums[DIMS_MAX];
    logic [63:0] cross_sums[DIMS_MAX*DIMS_MAX];
    int          elem_idx;
    int          frames_seen;
    logic        overflowed;

    mean_covariance_accumulator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .sample       (sample),
        .last_sample  (last_sample),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .row          (row),
        .col          (col),
        .row_mean     (row_mean),
        .covariance   (covariance),
        .frame_count  (frame_count),
        .status       (status),
        .last         (last)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int active_dims();
        if (dims_reg == 4'd0)
            return 1;
        if (dims_reg > DIMS_MAX)
            return DIMS_MAX;
        return int'(dims_reg);
    endfunction

    // signed division truncated toward zero
    function automatic logic [63:0] div_toward_zero(logic [63:0] num, logic [63:0] den);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] q;
        neg = num[63];
        mag = neg ? (64'd0 - num) : num;
        q = (den == 64'd0) ? 64'd0 : mag / den;
        return neg ? (64'd0 - q) : q;
    endfunction

    function automatic void clear_sums();
        for (int k = 0; k < DIMS_MAX; k++)
            dim_sums[k] = 64'd0;
        for (int k = 0; k < DIMS_MAX*DIMS_MAX; k++)
            cross_sums[k] = 64'd0;
        elem_idx = 0;
        frames_seen = 0;
        overflowed = 1'b0;
    endfunction

    // accumulate one sample and queue the statistics a final sample releases
    function automatic void absorb_sample(logic [15:0] value, logic last_flag);
        int          d;
        logic [1:0]  st;
        logic [63:0] n;
        logic [63:0] mean;
        logic [63:0] num;
        logic [63:0] cov;
        entry_t      e;
        d = active_dims();
        frame_buf[elem_idx] = {{48{value[15]}}, value};
        if (elem_idx + 1 >= d)
        begin
            if (frames_seen >= FRAMES_CAP)
                overflowed = 1'b1;
            else
            begin
                for (int i = 0; i < d; i++)
                begin
                    dim_sums[i] += frame_buf[i];
                    for (int j = 0; j < d; j++)
                        cross_sums[i*DIMS_MAX+j] += frame_buf[i] * frame_buf[j];
                end
                frames_seen++;
            end
            elem_idx = 0;
        end
        else
            elem_idx++;
        if (!last_flag)
            return;
        if (frames_seen == 0)
        begin
            e = '{row: 3'd0, col: 3'd0, row_mean: 24'd0, covariance: 32'd0,
                  frame_count: 13'd0, status: mca_pkg::STATUS_NO_FRAMES, last: 1'b1};
            expected_entries.push_back(e);
            clear_sums();
            return;
        end
        st = overflowed ? mca_pkg::STATUS_OVERFLOW
           : ((elem_idx != 0) ? mca_pkg::STATUS_PARTIAL : mca_pkg::STATUS_OK);
        n = 64'(frames_seen);
        for (int i = 0; i < d; i++)
        begin
            mean = div_toward_zero(dim_sums[i] * 64'd256, n);
            for (int j = 0; j < d; j++)
            begin
                num = n * cross_sums[i*DIMS_MAX+j] - dim_sums[i] * dim_sums[j];
                cov = div_toward_zero(num, n * n);
                e.row = i[2:0];
                e.col = j[2:0];
                e.row_mean = mean[23:0];
                e.covariance = cov[31:0];
                e.frame_count = n[12:0];
                e.status = st;
                e.last = (i == d - 1) && (j == d - 1);
                expected_entries.push_back(e);
            end
        end
        clear_sums();
    endfunction

    // driver: samples on start/busy, dimension writes only when the block is idle
    always @(posedge clk or negedge rst_n)
    begin
        logic       start_n;
        logic       cfg_n;
        logic [15:0] sample_n;
        logic       last_n;
        logic [3:0] data_n;
        logic       quiet;
        request_t   r;
        if (!rst_n)
        begin
            start       <= 1'b0;
            sample      <= '0;
            last_sample <= 1'b0;
            cfg_valid   <= 1'b0;
            cfg_data    <= '0;
            settle_count <= 0;
        end
        else
        begin
            start_n  = start;
            cfg_n    = cfg_valid;
            sample_n = sample;
            last_n   = last_sample;
            data_n   = cfg_data;
            if (start && !busy)
            begin
                absorb_sample(sample, last_sample);
                accepted_count++;
                start_n = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                dims_reg = cfg_data;
                cfg_n = 1'b0;
            end
            if (expected_entries.size() != 0 || start_n || cfg_n)
                settle_count <= 0;
            else
                settle_count <= settle_count + 1;
            quiet = (accepted_count > 60) && (accepted_count < 110);
            if (!start_n && !cfg_n && pending_reqs.size() != 0)
            begin
                if (pending_reqs[0].kind == REQ_SAMPLE)
                begin
                    if (quiet || $urandom_range(99) >= 14)
                    begin
                        r = pending_reqs.pop_front();
                        start_n = 1'b1;
                        sample_n = r.value;
                        last_n = r.last_flag;
                    end
                end
                else if (settle_count >= SETTLE && expected_entries.size() == 0)
                begin
                    r = pending_reqs.pop_front();
                    cfg_n = 1'b1;
                    data_n = r.dims;
                end
            end
            start       <= start_n;
            sample      <= sample_n;
            last_sample <= last_n;
            cfg_valid   <= cfg_n;
            cfg_data    <= data_n;
        end
    end

    // monitor: every strobed result against the oldest expectation
    always @(posedge clk)
    begin
        entry_t e;
        if (rst_n && result_valid)
        begin
            if (expected_entries.size() == 0)
            begin
                $error("unexpected result row=%0d col=%0d", row, col);
                fail_count++;
            end
            else
            begin
                e = expected_entries.pop_front();
                if (row !== e.row)
                begin
                    $error("row: expected %0d, actual %0d", e.row, row);
                    fail_count++;
                end
                if (col !== e.col)
                begin
                    $error("col: expected %0d, actual %0d", e.col, col);
                    fail_count++;
                end
                if (row_mean !== e.row_mean)
                begin
                    $error("row_mean: expected %0d, actual %0d",
                           $signed(e.row_mean), row_mean);
                    fail_count++;
                end
                if (covariance !== e.covariance)
                begin
                    $error("covariance: expected %0d, actual %0d",
                           $signed(e.covariance), covariance);
                    fail_count++;
                end
                if (frame_count !== e.frame_count)
                begin
                    $error("frame_count: expected %0d, actual %0d", e.frame_count, frame_count);
                    fail_count++;
                end
                if (status !== e.status)
                begin
                    $error("status: expected %0d, actual %0d", e.status, status);
                    fail_count++;
                end
                if (last !== e.last)
                begin
                    $error("last: expected %0d, actual %0d", e.last, last);
                    fail_count++;
                end
            end
        end
    end

    task automatic push_cfg(logic [3:0] d);
        request_t r;
        r = '{kind: REQ_CFG, value: 16'd0, last_flag: 1'b0, dims: d};
        pending_reqs.push_back(r);
    endtask

    task automatic push_sample(logic [15:0] v, logic lf);
        request_t r;
        r = '{kind: REQ_SAMPLE, value: v, last_flag: lf, dims: 4'd0};
        pending_reqs.push_back(r);
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(7))
            0: return 16'h7fff;
            1: return 16'h8000;
            default: return 16'($urandom_range(16'hffff));
        endcase
    endfunction

    // stimulus and end of run
    initial
    begin
        logic [15:0] edge_vals[8];
        int d;
        int frames;
        int extra;
        int total;
        int queued;
        fail_count = 0;
        accepted_count = 0;
        dims_reg = mca_pkg::DIMS_RESET;
        clear_sums();
        for (int k = 0; k < DIMS_MAX; k++)
            frame_buf[k] = 64'd0;
        edge_vals = '{16'h7fff, 16'h8000, 16'h0000, 16'h0001,
                      16'hffff, 16'h5555, 16'haaaa, 16'h0100};

        // one full frame of extreme values at the reset dimension count
        for (int k = 0; k < 8; k++)
            push_sample(edge_vals[k], k == 7);
        // out-of-range high count acts as eight; a lone sample leaves no frames
        push_cfg(4'd15);
        push_sample(16'h1234, 1'b1);
        // two frames plus a trailing partial frame
        push_cfg(4'd2);
        for (int k = 0; k < 5; k++)
            push_sample(edge_vals[k], k == 4);
        // zero count acts as one
        push_cfg(4'd0);
        for (int k = 0; k < 3; k++)
            push_sample(edge_vals[k+4], k == 2);

        // random data sets, mostly small
        queued = 0;
        while (queued < 160)
        begin
            d = $urandom_range(9);
            push_cfg(d[3:0]);
            if (d == 0)
                d = 1;
            if (d > DIMS_MAX)
                d = DIMS_MAX;
            frames = ($urandom_range(9) == 0) ? $urandom_range(12, 5) : $urandom_range(4, 1);
            extra = (d > 1 && $urandom_range(3) == 0) ? $urandom_range(d - 1, 1) : 0;
            if (d > 1 && $urandom_range(11) == 0)
            begin
                frames = 0;
                extra = $urandom_range(d - 1, 1);
            end
            total = frames * d + extra;
            for (int k = 0; k < total; k++)
                push_sample(pick_value(), k == total - 1);
            queued += total;
        end
        push_cfg(mca_pkg::DIMS_RESET);

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        stimulus_done = 1'b0;
        while (!stimulus_done)
        begin
            @(posedge clk);
            stimulus_done = pending_reqs.size() == 0 && !start && !cfg_valid
                            && expected_entries.size() == 0;
        end
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0 && expected_entries.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // guard against a hang
    initial
    begin
        #12ms;
        $display("status: fail");
        $finish;
    end

endmodule
